FILE: rtl/core/bero5_pkg.sv
// Shared sizes, codes, constant tables and item types of the 5x5 disk erosion block.
package bero5_pkg;

  localparam int MAX_LINE_LENGTH = 1024;
  localparam int MAX_LINE_COUNT  = 1024;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     DIM_RESET       = CFG_W'(1024);

  // counter widths
  localparam int LEN_W  = $clog2(MAX_LINE_LENGTH + 1);
  localparam int CNT_W  = $clog2(MAX_LINE_COUNT + 1);
  localparam int POS_W  = $clog2(MAX_LINE_LENGTH);
  localparam int OROW_W = $clog2(MAX_LINE_COUNT);
  localparam int ROW_W  = $clog2(MAX_LINE_COUNT + 4);
  localparam int LEAD_W = $clog2(2 * MAX_LINE_LENGTH + 3);

  // window and column memory
  localparam int WIN_SIZE = 5;
  localparam int MEM_W    = WIN_SIZE - 1;
  localparam logic [WIN_SIZE-1:0][WIN_SIZE-1:0] DISK_MASK = {
    5'b01110, 5'b11111, 5'b11111, 5'b11111, 5'b01110
  };

  // output queue
  localparam int OUT_Q_DEPTH = 3;
  localparam int QCNT_W      = $clog2(OUT_Q_DEPTH + 1);
  localparam int QPTR_W      = $clog2(OUT_Q_DEPTH);

  // request codes and pixel values
  localparam logic       REQ_PIXEL = 1'b0;
  localparam logic       REQ_FLUSH = 1'b1;
  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       is_last;
    logic       any_white;
  } out_item_t;

  // one column shift into the window, from the sequencer to the window datapath
  typedef struct packed {
    logic                valid;
    logic                pix;
    logic                emit;
    logic                last;
    logic [POS_W-1:0]    addr;
    logic [WIN_SIZE-1:0] rowmask;
    logic [WIN_SIZE-1:0] colmask;
  } col_req_t;

endpackage

FILE: rtl/core/binary_erode_5x5_disk.sv
// Top level of the streaming binary erosion with a 5x5 disk.
//
//   channel   signals                               transfer
//   cfg       cfg_wr_en, cfg_index, cfg_data        write on cfg_wr_en, no wait
//   in        in_valid, in_ready, in_item           transaction on valid & ready
//   out       out_valid, out_ready, out_item        transaction on valid & ready
//
// One pixel or flush transaction per cycle while in_ready is high; each one passes the column memory
// read, then the window and disk test, and its result is queued before it reaches out_valid.
// Results lag the image by two lines plus two pixels; flush transactions drain the rest.
// For an image of N < 2L+2 pixels, in_ready drops after the last pixel until 2L+2 columns
// have gone into the window, while blank columns are pushed into it.
// Reset is synchronous; the column memory is never cleared since border masks hide every
// entry not yet written in the current image. in_ready drops when the queue is about full.
module binary_erode_5x5_disk (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [bero5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bero5_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bero5_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bero5_pkg::out_item_t             out_item
);

  bero5_pkg::col_req_t          col_req;
  bero5_pkg::out_item_t         q_item;
  logic                         q_wr;
  logic                         restart;
  logic [bero5_pkg::QCNT_W-1:0] q_count;

  bero5_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .q_count      (q_count),
    .q_wr_pending (q_wr),
    .col_req      (col_req),
    .restart      (restart)
  );

  bero5_window u_window (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .col_req (col_req),
    .q_wr    (q_wr),
    .q_item  (q_item)
  );

  bero5_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_wr),
    .wr_item   (q_item),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/core/bero5_ctrl.sv
// Sequencer: dimensions, scan counters, output lag, drain catch-up and border masks.
module bero5_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [bero5_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bero5_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bero5_pkg::in_item_t                 in_item,
  input  logic [bero5_pkg::QCNT_W-1:0]        q_count,
  input  logic                                q_wr_pending,
  output bero5_pkg::col_req_t                 col_req,
  output logic                                restart
);

  localparam int SUM_W = bero5_pkg::QCNT_W + 1;

  function automatic logic [bero5_pkg::CNT_W-1:0] clamp_count(
    input logic [bero5_pkg::CFG_W-1:0] v
  );
    if (v == '0) return bero5_pkg::CNT_W'(1);
    if (int'(v) > bero5_pkg::MAX_LINE_COUNT) return bero5_pkg::CNT_W'(bero5_pkg::MAX_LINE_COUNT);
    return bero5_pkg::CNT_W'(v);
  endfunction

  function automatic logic [bero5_pkg::LEN_W-1:0] clamp_length(
    input logic [bero5_pkg::CFG_W-1:0] v
  );
    if (v == '0) return bero5_pkg::LEN_W'(1);
    if (int'(v) > bero5_pkg::MAX_LINE_LENGTH) begin
      return bero5_pkg::LEN_W'(bero5_pkg::MAX_LINE_LENGTH);
    end
    return bero5_pkg::LEN_W'(v);
  endfunction

  logic [bero5_pkg::CNT_W-1:0]    line_count;
  logic [bero5_pkg::LEN_W-1:0]    line_length;
  logic [bero5_pkg::ROW_W-1:0]    in_line;
  logic [bero5_pkg::POS_W-1:0]    in_pos;
  logic [bero5_pkg::OROW_W-1:0]   out_line;
  logic [bero5_pkg::POS_W-1:0]    out_pos;
  logic [bero5_pkg::LEAD_W-1:0]   lead;
  logic [bero5_pkg::LEAD_W-1:0]   target;
  logic                           all_in, primed, catchup, space, accept, is_flush;
  logic                           do_push, emit, in_wrap, out_wrap, out_last;
  logic [bero5_pkg::CNT_W:0]      ro_p1, ro_p2, cnt_ext;
  logic [bero5_pkg::LEN_W:0]      po_p1, po_p2, len_ext;
  logic [bero5_pkg::WIN_SIZE-1:0] rowmask, colmask;

  // outputs start once 2L+2 columns have gone into the window
  assign target   = bero5_pkg::LEAD_W'({line_length, 1'b0}) + bero5_pkg::LEAD_W'(2);
  assign all_in   = in_line >= bero5_pkg::ROW_W'(line_count);
  assign primed   = lead == target;
  // small image done before the lag is built up: push blank columns internally
  assign catchup  = all_in && !primed;
  assign space    = (SUM_W'(q_count) + SUM_W'(q_wr_pending))
                    <= SUM_W'(bero5_pkg::OUT_Q_DEPTH - 1);
  assign in_ready = !catchup && space;
  assign accept   = in_valid && in_ready;
  assign is_flush = in_item.req_type == bero5_pkg::REQ_FLUSH;
  assign do_push  = !cfg_wr_en && (catchup || (accept && (is_flush == all_in)));
  assign emit     = do_push && primed;

  assign in_wrap  = (bero5_pkg::LEN_W'(in_pos) + bero5_pkg::LEN_W'(1)) == line_length;
  assign out_wrap = (bero5_pkg::LEN_W'(out_pos) + bero5_pkg::LEN_W'(1)) == line_length;

  assign cnt_ext  = (bero5_pkg::CNT_W + 1)'(line_count);
  assign len_ext  = (bero5_pkg::LEN_W + 1)'(line_length);
  assign ro_p1    = (bero5_pkg::CNT_W + 1)'(out_line) + (bero5_pkg::CNT_W + 1)'(1);
  assign ro_p2    = (bero5_pkg::CNT_W + 1)'(out_line) + (bero5_pkg::CNT_W + 1)'(2);
  assign po_p1    = (bero5_pkg::LEN_W + 1)'(out_pos) + (bero5_pkg::LEN_W + 1)'(1);
  assign po_p2    = (bero5_pkg::LEN_W + 1)'(out_pos) + (bero5_pkg::LEN_W + 1)'(2);
  assign out_last = out_wrap && (ro_p1 == cnt_ext);

  // bit k covers line/position (center - 2 + k)
  assign rowmask = {ro_p2 < cnt_ext, ro_p1 < cnt_ext, 1'b1, out_line != '0,
                    out_line >= bero5_pkg::OROW_W'(2)};
  assign colmask = {po_p2 < len_ext, po_p1 < len_ext, 1'b1, out_pos != '0,
                    out_pos >= bero5_pkg::POS_W'(2)};

  assign restart = cfg_wr_en && ((cfg_index == bero5_pkg::REG_LINE_COUNT) ||
                                 (cfg_index == bero5_pkg::REG_LINE_LENGTH));

  always_comb begin
    col_req.valid   = do_push;
    col_req.pix     = do_push && !all_in && (in_item.pixel_value != '0);
    col_req.emit    = emit;
    col_req.last    = out_last;
    col_req.addr    = in_pos;
    col_req.rowmask = rowmask;
    col_req.colmask = colmask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= clamp_count(bero5_pkg::DIM_RESET);
      line_length <= clamp_length(bero5_pkg::DIM_RESET);
      in_line     <= '0;
      in_pos      <= '0;
      out_line    <= '0;
      out_pos     <= '0;
      lead        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bero5_pkg::REG_LINE_COUNT: begin
          line_count <= clamp_count(cfg_data);
        end
        bero5_pkg::REG_LINE_LENGTH: begin
          line_length <= clamp_length(cfg_data);
        end
        default: begin
        end
      endcase
      if (restart) begin
        in_line  <= '0;
        in_pos   <= '0;
        out_line <= '0;
        out_pos  <= '0;
        lead     <= '0;
      end
    end else if (do_push) begin
      if (emit && out_last) begin
        in_line  <= '0;
        in_pos   <= '0;
        out_line <= '0;
        out_pos  <= '0;
        lead     <= '0;
      end else begin
        if (in_wrap) begin
          in_pos  <= '0;
          in_line <= in_line + bero5_pkg::ROW_W'(1);
        end else begin
          in_pos <= in_pos + bero5_pkg::POS_W'(1);
        end
        if (!primed) begin
          lead <= lead + bero5_pkg::LEAD_W'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_pos  <= '0;
            out_line <= out_line + bero5_pkg::OROW_W'(1);
          end else begin
            out_pos <= out_pos + bero5_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  // drain never runs more than three virtual lines past the image (one-pixel lines)
  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    in_line <= bero5_pkg::ROW_W'(line_count) + bero5_pkg::ROW_W'(3))
    else $error("scan counter ran past the drain region");

  a_image_wrap: assert property (@(posedge clk) disable iff (rst)
    (emit && out_last) |=> (in_line == '0 && lead == '0 && !all_in))
    else $error("counters not rewound after the last pixel");

endmodule

FILE: rtl/core/bero5_window.sv
// Column memory read-modify-write with forwarding, 5x5 window and disk test.
module bero5_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  bero5_pkg::col_req_t  col_req,
  output logic                 q_wr,
  output bero5_pkg::out_item_t q_item
);

  // entry p holds the four previous lines at position p, oldest in bit 0
  logic [bero5_pkg::MEM_W-1:0] col_mem [bero5_pkg::MAX_LINE_LENGTH];
  logic [bero5_pkg::MEM_W-1:0] rd_data, fwd_data;
  logic                        fwd;
  bero5_pkg::col_req_t         s1;
  logic [bero5_pkg::WIN_SIZE-1:0]                              newcol;
  logic [bero5_pkg::WIN_SIZE-1:0][bero5_pkg::WIN_SIZE-1:0]     win, win_next;
  logic                        white, white_seen;

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      col_mem[s1.addr] <= newcol[bero5_pkg::WIN_SIZE-1:1];
    end
    if (col_req.valid) begin
      rd_data <= col_mem[col_req.addr];
    end
  end

  // back-to-back access to one column (one-pixel lines) reads the stale word, so the word just written is forwarded
  assign newcol   = {s1.pix, (fwd ? fwd_data : rd_data)};
  assign win_next = {newcol, win[bero5_pkg::WIN_SIZE-1:1]};

  always_comb begin
    white = 1'b1;
    for (int i = 0; i < bero5_pkg::WIN_SIZE; i++) begin
      for (int j = 0; j < bero5_pkg::WIN_SIZE; j++) begin
        if (bero5_pkg::DISK_MASK[i][j] &&
            !(s1.rowmask[i] && s1.colmask[j] && win_next[j][i])) begin
          white = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1.valid   <= 1'b0;
      fwd        <= 1'b0;
      white_seen <= 1'b0;
    end else begin
      s1  <= col_req;
      fwd <= s1.valid && col_req.valid && (s1.addr == col_req.addr);
      if (s1.valid && s1.emit) begin
        white_seen <= !s1.last && (white_seen || white);
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= newcol[bero5_pkg::WIN_SIZE-1:1];
    if (s1.valid) begin
      win <= win_next;
    end
  end

  always_comb begin
    q_wr             = s1.valid && s1.emit;
    q_item.out_pixel = white ? bero5_pkg::PIX_WHITE : bero5_pkg::PIX_BLACK;
    q_item.is_last   = s1.last;
    q_item.any_white = s1.last && (white_seen || white);
  end

  a_summary_clear: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.emit && s1.last) |=> !white_seen)
    else $error("white summary carried past the end of an image");

endmodule

FILE: rtl/core/bero5_outq.sv
// Three-entry result queue that decouples the window pipeline from the output channel.
module bero5_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  bero5_pkg::out_item_t          wr_item,
  output logic [bero5_pkg::QCNT_W-1:0]  count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bero5_pkg::out_item_t          out_item
);

  function automatic logic [bero5_pkg::QPTR_W-1:0] next_ptr(
    input logic [bero5_pkg::QPTR_W-1:0] p
  );
    if (p == bero5_pkg::QPTR_W'(bero5_pkg::OUT_Q_DEPTH - 1)) return '0;
    return p + bero5_pkg::QPTR_W'(1);
  endfunction

  bero5_pkg::out_item_t          q [bero5_pkg::OUT_Q_DEPTH];
  logic [bero5_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic                          rd_en;

  assign out_valid = count != '0;
  assign out_item  = q[rd_ptr];
  assign rd_en     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + bero5_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - bero5_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= wr_item;
    end
  end

  // the sequencer's credit check must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != bero5_pkg::QCNT_W'(bero5_pkg::OUT_Q_DEPTH)))
    else $error("result queue written while full");

endmodule
